@@ rtl/core/fan_curve_hysteresis_lookup_defines.svh @@
// Assertion macros for the fan curve block.
// Depends on nothing; included by the top level only.
`ifndef FAN_CURVE_HYSTERESIS_LOOKUP_DEFINES_SVH
`define FAN_CURVE_HYSTERESIS_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
`define FCHL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fchl assertion failed");
`define FCHL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fchl assertion failed");
`else
`define FCHL_ASSERT_NOW(label, clk, rst, ante, cons)
`define FCHL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/fchl_pkg.sv @@
// Shared constants and types for the fan curve block.
// Depends on nothing.
package fchl_pkg;

  localparam int ENTRIES   = 8;
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int PICK_W    = $clog2(ENTRIES);
  localparam int LAST      = ENTRIES - 1;
  localparam int ENTRY_W   = 16;
  localparam int TEMP_W    = 8;
  localparam int DUTY_W    = 7;

  localparam logic [7:0] DUTY_MAX = 8'd100;

  typedef logic [REG_COUNT-1:0][ENTRY_W-1:0] entry_table_t;

  localparam entry_table_t ENTRY_RESET = {
    16'd23140, 16'd22615, 16'd21834, 16'd20541,
    16'd18737, 16'd16164, 16'd11543, 16'd3850
  };

  typedef struct packed {
    logic [DUTY_W-1:0]        duty;
    logic signed [TEMP_W-1:0] ref_next;
  } sel_t;

endpackage

@@ rtl/core/fchl_cfg_regs.sv @@
// Breakpoint register file, written through the plain config port.
// Depends on fchl_pkg.
module fchl_cfg_regs import fchl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [ENTRY_W-1:0]   cfg_data,
  output entry_table_t         entries
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= ENTRY_RESET;
    end else if (cfg_we) begin
      entries[cfg_index] <= cfg_data;
    end
  end

endmodule

@@ rtl/core/fchl_select.sv @@
// Breakpoint compare and priority pick with step hysteresis.
// Depends on fchl_pkg.
module fchl_select import fchl_pkg::*; (
  input  entry_table_t             entries,
  input  logic signed [TEMP_W-1:0] temp,
  input  logic signed [TEMP_W-1:0] ref_temp,
  output sel_t                     sel
);

  logic signed [TEMP_W-1:0] bp_t [ENTRIES];
  logic [7:0]               bp_d [ENTRIES];
  logic [PICK_W-1:0]        pick_up;
  logic [PICK_W-1:0]        pick_dn;
  logic [PICK_W-1:0]        pick;
  logic [7:0]               raw_duty;
  logic                     below_first;
  logic                     at_last;

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      bp_t[k] = signed'(entries[k][15:8]);
      bp_d[k] = entries[k][7:0];
    end
  end

  always_comb begin
    pick_up = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (temp >= bp_t[k]) pick_up = PICK_W'(k);
    end
    pick_dn = PICK_W'(LAST);
    for (int k = LAST; k >= 0; k--) begin
      if (temp <= bp_t[k]) pick_dn = PICK_W'(k);
    end
  end

  assign below_first = temp < bp_t[0];
  assign at_last     = temp >= bp_t[LAST];

  always_comb begin
    pick = (temp > ref_temp) ? pick_up : pick_dn;
    if (below_first) begin
      pick = '0;
    end else if (at_last) begin
      pick = PICK_W'(LAST);
    end
    raw_duty = bp_d[pick];
    sel.duty = (raw_duty > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : raw_duty[DUTY_W-1:0];
    sel.ref_next = (below_first || at_last) ? temp : bp_t[pick];
  end

endmodule

@@ rtl/core/fan_curve_hysteresis_lookup.sv @@
// Top level of the fan curve block: input register, pick, result register.
// Depends on fchl_pkg, fchl_cfg_regs, fchl_select and the defines header.
//
//   port group  dir  beat
//   s_axis      in   tdata[7:0] = temp_c
//   m_axis      out  tdata[6:0] = duty_pct, tdata[7] = 0
//   cfg         in   cfg_we / cfg_index / cfg_data (one register per write)
//
// One beat per cycle sustained while m_axis accepts; a beat passes the input register, then the result register.
// The kept reference updates as a beat moves from input to result register.
// A stall on m_axis holds both stages; the input stage still takes a beat
// while the result register waits, if the input register is empty.
// Reset (sync, active high) empties both stages and restores breakpoints.
`include "fan_curve_hysteresis_lookup_defines.svh"

module fan_curve_hysteresis_lookup import fchl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] temp_c
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [6:0] duty_pct, [7] zero
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [ENTRY_W-1:0]   cfg_data
);

  entry_table_t             entries;
  logic                     in_valid;
  logic signed [TEMP_W-1:0] in_temp;
  logic signed [TEMP_W-1:0] reference_temp;
  logic [DUTY_W-1:0]        out_duty;
  logic                     advance;
  logic                     move;
  sel_t                     sel;

  fchl_cfg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entries   (entries)
  );

  fchl_select u_sel (
    .entries  (entries),
    .temp     (in_temp),
    .ref_temp (reference_temp),
    .sel      (sel)
  );

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign move          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_temp <= signed'(s_axis_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid  <= 1'b0;
      reference_temp <= '0;
    end else begin
      if (advance) m_axis_tvalid <= in_valid;
      if (move) reference_temp <= sel.ref_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_duty <= sel.duty;
    end
  end

  assign m_axis_tdata = {1'b0, out_duty};

  `FCHL_ASSERT_NOW(a_duty_range, clk, rst, m_axis_tvalid, m_axis_tdata <= DUTY_MAX)
  `FCHL_ASSERT_NEXT(a_move_gives_result, clk, rst, move, m_axis_tvalid)
  `FCHL_ASSERT_NEXT(a_ref_hold, clk, rst, !move, $stable(reference_temp))
  `FCHL_ASSERT_NOW(a_stall_full, clk, rst, !s_axis_tready, in_valid && m_axis_tvalid)

endmodule
